### src/tsbb_pkg.sv
// Shared widths, codes and reset values of the timestamped sample bracket buffer.
// Used by the register block and the top level; depends on nothing.
package tsbb_pkg;

  localparam int STAMP_W  = 63;
  localparam int COMP_W   = 16;
  localparam int QUAT_W   = 4 * COMP_W;
  localparam int WINDOW_W = 34;
  localparam int WPAD_W   = STAMP_W - WINDOW_W;

  localparam int APB_AW   = 4;
  localparam int APB_DW   = 64;

  // register index, taken from paddr[3] (8-byte register pitch)
  localparam logic REG_WINDOW = 1'b0;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int MIN_KEEP = 2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 34'd500000000;

endpackage

### src/tsbb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package needed.
module tsbb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tsbb_regs.sv
// APB-style configuration port holding the window register.
// Depends on tsbb_pkg.
module tsbb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsbb_pkg::APB_AW-1:0]     paddr,
  input  logic [tsbb_pkg::APB_DW-1:0]     pwdata,
  output logic [tsbb_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  output logic [tsbb_pkg::WINDOW_W-1:0]   window
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= tsbb_pkg::WINDOW_RESET;
    end else if (wr && (paddr[3] == tsbb_pkg::REG_WINDOW)) begin
      window <= pwdata[tsbb_pkg::WINDOW_W-1:0];
    end
  end

  // decode the read; unused address bits are ignored
  always_comb begin
    unique case (paddr[3])
      tsbb_pkg::REG_WINDOW:
        prdata = {{(tsbb_pkg::APB_DW - tsbb_pkg::WINDOW_W){1'b0}}, window};
      default: prdata = '0;
    endcase
  end

endmodule

### src/timestamped_sample_bracket_buffer.sv
// Top level of the timestamped sample bracket buffer: control sequencer around two
// sample RAMs. Depends on tsbb_pkg, tsbb_ram and tsbb_regs.
//
// A request is taken when start is high and busy is low. A push (operation 0)
// writes its sample at the accept edge and gives no result. It then holds busy
// for a read and a compare (S_EVRD, S_EVCMP) per dropped oldest sample, and for
// one more such pair for the age check that keeps the oldest, unless the drops
// have already brought the count down to two. It does not hold busy at all when
// two or fewer samples are held after the write. A query (operation 1) gives one
// result on the result ports, marked by done for a single cycle that cannot be
// held off: capture it then. With fewer than two samples held, the query goes
// straight to S_QOUT. Otherwise the stamp RAM is scanned from the oldest sample,
// one read per cycle. A query that finds its bracket at ring position p reads
// the earlier and then the later sample (S_QRB, S_QRA) before S_QOUT. A query
// that stops at the oldest sample (p = 0) or runs off the newest one (p = held - 1)
// finds nothing. The stamp RAM has a single read port. A new request may be taken
// in the cycle done is high.
module timestamped_sample_bracket_buffer #(
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // request channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   operation,
  input  logic [tsbb_pkg::STAMP_W-1:0]           stamp_ns,
  input  logic signed [tsbb_pkg::COMP_W-1:0]     quat_w,
  input  logic signed [tsbb_pkg::COMP_W-1:0]     quat_x,
  input  logic signed [tsbb_pkg::COMP_W-1:0]     quat_y,
  input  logic signed [tsbb_pkg::COMP_W-1:0]     quat_z,
  // result channel
  output logic                                   done,
  output logic                                   found,
  output logic [tsbb_pkg::STAMP_W-1:0]           before_stamp,
  output logic signed [tsbb_pkg::COMP_W-1:0]     before_w,
  output logic signed [tsbb_pkg::COMP_W-1:0]     before_x,
  output logic signed [tsbb_pkg::COMP_W-1:0]     before_y,
  output logic signed [tsbb_pkg::COMP_W-1:0]     before_z,
  output logic [tsbb_pkg::STAMP_W-1:0]           after_stamp,
  output logic signed [tsbb_pkg::COMP_W-1:0]     after_w,
  output logic signed [tsbb_pkg::COMP_W-1:0]     after_x,
  output logic signed [tsbb_pkg::COMP_W-1:0]     after_y,
  output logic signed [tsbb_pkg::COMP_W-1:0]     after_z,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tsbb_pkg::APB_AW-1:0]            paddr,
  input  logic [tsbb_pkg::APB_DW-1:0]            pwdata,
  output logic [tsbb_pkg::APB_DW-1:0]            prdata,
  output logic                                   pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL     = CW'(DEPTH);
  localparam logic [CW-1:0] KEEP     = CW'(tsbb_pkg::MIN_KEEP);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVRD  = 3'd1;
  localparam logic [2:0] S_EVCMP = 3'd2;
  localparam logic [2:0] S_QSCAN = 3'd3;
  localparam logic [2:0] S_QRB   = 3'd4;
  localparam logic [2:0] S_QRA   = 3'd5;
  localparam logic [2:0] S_QOUT  = 3'd6;

  logic [2:0]                      state;
  logic [AW-1:0]                   oldest;
  logic [CW-1:0]                   held;
  logic [tsbb_pkg::STAMP_W-1:0]    q_stamp;
  logic [CW-1:0]                   rd_pos;
  logic [AW-1:0]                   rd_slot;
  logic                            pend_valid;
  logic [CW-1:0]                   pend_pos;
  logic [AW-1:0]                   pend_slot;
  logic [AW-1:0]                   hit_slot;
  logic                            hit;

  logic [tsbb_pkg::WINDOW_W-1:0]   window;
  logic                            accept;
  logic                            push_we;
  logic                            full_ring;
  logic [SW-1:0]                   tail_sum;
  logic [AW-1:0]                   push_slot;
  logic [CW-1:0]                   held_after;
  logic [AW-1:0]                   before_slot;
  logic [AW-1:0]                   raddr;
  logic [tsbb_pkg::STAMP_W-1:0]    stamp_rdata;
  logic [tsbb_pkg::QUAT_W-1:0]     quat_rdata;
  logic [tsbb_pkg::QUAT_W-1:0]     quat_wdata;
  logic [tsbb_pkg::STAMP_W-1:0]    age;
  logic                            keep_oldest;
  logic                            issue;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  tsbb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign push_we = accept && (operation == tsbb_pkg::OP_PUSH);

  // next free slot: oldest + held, wrapped once around the ring
  assign full_ring  = (held == FULL);
  assign tail_sum   = SW'(oldest) + SW'(held);
  assign push_slot  = full_ring ? oldest :
                      (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign held_after = full_ring ? held : held + 1'b1;
  assign quat_wdata = {quat_w, quat_x, quat_y, quat_z};

  assign before_slot = (hit_slot == '0) ? LAST_SLOT : hit_slot - 1'b1;

  // age of the oldest sample against the newest; a newer oldest stamp never drops
  assign age         = q_stamp - stamp_rdata;
  assign keep_oldest = (q_stamp < stamp_rdata) ||
                       (age <= {{tsbb_pkg::WPAD_W{1'b0}}, window});

  assign issue = (rd_pos < held);

  always_comb begin
    unique case (state)
      S_EVRD:  raddr = oldest;
      S_QSCAN: raddr = rd_slot;
      S_QRB:   raddr = before_slot;
      default: raddr = hit_slot;
    endcase
  end

  tsbb_ram #(.WIDTH(tsbb_pkg::STAMP_W), .DEPTH(DEPTH)) u_stamp_ram (
    .clk   (clk),
    .we    (push_we),
    .waddr (push_slot),
    .wdata (stamp_ns),
    .raddr (raddr),
    .rdata (stamp_rdata)
  );

  tsbb_ram #(.WIDTH(tsbb_pkg::QUAT_W), .DEPTH(DEPTH)) u_quat_ram (
    .clk   (clk),
    .we    (push_we),
    .waddr (push_slot),
    .wdata (quat_wdata),
    .raddr (raddr),
    .rdata (quat_rdata)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      oldest     <= '0;
      held       <= '0;
      pend_valid <= 1'b0;
      hit        <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= (state == S_QOUT);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            q_stamp <= stamp_ns;
            if (operation == tsbb_pkg::OP_PUSH) begin
              // overwrite the oldest on a full ring, else append
              if (full_ring) begin
                oldest <= slot_inc(oldest);
              end
              held <= held_after;
              if (held_after > KEEP) begin
                state <= S_EVRD;
              end
            end else if (held < KEEP) begin
              hit   <= 1'b0;
              state <= S_QOUT;
            end else begin
              rd_pos     <= '0;
              rd_slot    <= oldest;
              pend_valid <= 1'b0;
              state      <= S_QSCAN;
            end
          end
        end
        S_EVRD: begin
          state <= S_EVCMP;
        end
        S_EVCMP: begin
          if (keep_oldest) begin
            state <= S_IDLE;
          end else begin
            // drop the oldest and check the next one while enough remain
            oldest <= slot_inc(oldest);
            held   <= held - 1'b1;
            state  <= ((held - 1'b1) > KEEP) ? S_EVRD : S_IDLE;
          end
        end
        S_QSCAN: begin
          // one read issued per cycle, compared in the next cycle
          if (issue) begin
            rd_pos  <= rd_pos + 1'b1;
            rd_slot <= slot_inc(rd_slot);
          end
          pend_valid <= issue;
          pend_pos   <= rd_pos;
          pend_slot  <= rd_slot;
          if (pend_valid) begin
            if (stamp_rdata >= q_stamp) begin
              if (pend_pos == '0) begin
                hit   <= 1'b0;
                state <= S_QOUT;
              end else begin
                hit      <= 1'b1;
                hit_slot <= pend_slot;
                state    <= S_QRB;
              end
            end else if (pend_pos == held - 1'b1) begin
              hit   <= 1'b0;
              state <= S_QOUT;
            end
          end
        end
        S_QRB: begin
          state <= S_QRA;
        end
        S_QRA: begin
          state <= S_QOUT;
        end
        S_QOUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result registers; cleared fields on a miss
  always_ff @(posedge clk) begin
    if (state == S_QRA) begin
      before_stamp <= stamp_rdata;
      {before_w, before_x, before_y, before_z} <= quat_rdata;
    end else if (state == S_QOUT) begin
      if (hit) begin
        found       <= 1'b1;
        after_stamp <= stamp_rdata;
        {after_w, after_x, after_y, after_z} <= quat_rdata;
      end else begin
        found        <= 1'b0;
        before_stamp <= '0;
        before_w     <= '0;
        before_x     <= '0;
        before_y     <= '0;
        before_z     <= '0;
        after_stamp  <= '0;
        after_w      <= '0;
        after_x      <= '0;
        after_y      <= '0;
        after_z      <= '0;
      end
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst) held <= FULL)
    else $error("held count beyond ring depth");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == tsbb_pkg::OP_QUERY) |=> busy)
    else $error("query accepted without holding busy");

  a_found_needs_pair: assert property (@(posedge clk) disable iff (rst)
    done && found |-> held >= KEEP)
    else $error("bracket reported with fewer than two samples");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_QSCAN) && pend_valid |-> pend_pos < held)
    else $error("scan compared a slot outside the held samples");

  a_done_from_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_QOUT))
    else $error("result strobe without a finished query");

endmodule

### bench/testbench.sv
// Self-checking bench for the timestamped sample bracket buffer: pushes and
// bracket queries checked against a behavioural ring model kept in the bench.
// Depends on tsbb_pkg and the timestamped_sample_bracket_buffer top level.
module testbench;

  localparam int STAMP_W  = tsbb_pkg::STAMP_W;
  localparam int COMP_W   = tsbb_pkg::COMP_W;
  localparam int WINDOW_W = tsbb_pkg::WINDOW_W;
  localparam int APB_AW   = tsbb_pkg::APB_AW;
  localparam int APB_DW   = tsbb_pkg::APB_DW;

  localparam int DEPTH = 64;
  // cycles with nothing accepted and no result before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  // longest push: a read and a compare per dropped sample plus the final age check
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
  localparam int MAX_REPORTS = 100;
  localparam logic [APB_AW-1:0] WINDOW_ADDR = {tsbb_pkg::REG_WINDOW, 3'b000};
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
  localparam logic [63:0] WINDOW_TOP = 64'd10000000000;

  typedef struct packed {
    logic signed [COMP_W-1:0] w;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } quat_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    quat_t              q;
  } sample_t;

  typedef struct packed {
    logic               op;
    logic [STAMP_W-1:0] stamp;
    quat_t              q;
  } request_t;

  typedef struct packed {
    logic    found;
    sample_t earlier;
    sample_t later;
  } bracket_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      start = 1'b0;
  logic                      busy;
  logic                      operation = tsbb_pkg::OP_PUSH;
  logic [STAMP_W-1:0]        stamp_ns = '0;
  logic signed [COMP_W-1:0]  quat_w = '0;
  logic signed [COMP_W-1:0]  quat_x = '0;
  logic signed [COMP_W-1:0]  quat_y = '0;
  logic signed [COMP_W-1:0]  quat_z = '0;
  logic                      done;
  logic                      found;
  logic [STAMP_W-1:0]        before_stamp;
  logic signed [COMP_W-1:0]  before_w, before_x, before_y, before_z;
  logic [STAMP_W-1:0]        after_stamp;
  logic signed [COMP_W-1:0]  after_w, after_x, after_y, after_z;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  timestamped_sample_bracket_buffer #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .operation(operation), .stamp_ns(stamp_ns),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .found(found),
    .before_stamp(before_stamp), .before_w(before_w), .before_x(before_x),
    .before_y(before_y), .before_z(before_z),
    .after_stamp(after_stamp), .after_w(after_w), .after_x(after_x),
    .after_y(after_y), .after_z(after_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Ring model: the bench's own copy of the sample store and the window.
  // ---------------------------------------------------------------------------
  sample_t             ring_samples [DEPTH];
  int                  ring_oldest = 0;
  int                  ring_held = 0;
  logic [WINDOW_W-1:0] window_model = tsbb_pkg::WINDOW_RESET;

  request_t pending_requests [$];
  bracket_t awaited_brackets [$];
  int       idle_pct = 0;
  int       mismatches = 0;
  logic [STAMP_W-1:0] clock_ns = '0;
  logic [STAMP_W-1:0] recent_stamps [$];

  // Append a sample, overwriting the oldest on a full ring, then age out the
  // oldest while more than the minimum are held and the span beats the window.
  task automatic ring_push(input sample_t s);
    int slot;
    logic [STAMP_W-1:0] old;
    if (ring_held >= DEPTH) begin
      slot = ring_oldest;
      ring_oldest = (ring_oldest + 1) % DEPTH;
    end else begin
      slot = (ring_oldest + ring_held) % DEPTH;
      ring_held++;
    end
    ring_samples[slot] = s;
    while (ring_held > tsbb_pkg::MIN_KEEP) begin
      old = ring_samples[ring_oldest].stamp;
      // an oldest stamp above the newest one stops the ageing
      if (s.stamp < old || s.stamp - old <= window_model) break;
      ring_oldest = (ring_oldest + 1) % DEPTH;
      ring_held--;
    end
  endtask

  // Scan from the oldest sample for the first stamp at or after t; the pair is
  // that sample and its predecessor, else a zeroed not-found result.
  function automatic bracket_t ring_bracket(input logic [STAMP_W-1:0] t);
    bracket_t r;
    int pos;
    r = '0;
    if (ring_held >= tsbb_pkg::MIN_KEEP) begin
      pos = 0;
      while (pos < ring_held && ring_samples[(ring_oldest + pos) % DEPTH].stamp < t)
        pos++;
      if (pos > 0 && pos < ring_held) begin
        r.found   = 1'b1;
        r.earlier = ring_samples[(ring_oldest + pos - 1) % DEPTH];
        r.later   = ring_samples[(ring_oldest + pos) % DEPTH];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: hold a request until it is taken, then model it and
  // offer the next one unless this cycle is to stay idle.
  // ---------------------------------------------------------------------------
  request_t cur_request;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur_request.op == tsbb_pkg::OP_PUSH)
          ring_push({cur_request.stamp, cur_request.q});
        else
          awaited_brackets.insert(awaited_brackets.size(), ring_bracket(cur_request.stamp));
      end
      if (!start || !busy) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_request = pending_requests[0];
          pending_requests.delete(0);
          operation <= cur_request.op;
          stamp_ns  <= cur_request.stamp;
          quat_w    <= cur_request.q.w;
          quat_x    <= cur_request.q.x;
          quat_y    <= cur_request.q.y;
          quat_z    <= cur_request.q.z;
          start     <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: results cannot be held off, so take each one on done.
  // ---------------------------------------------------------------------------
  task automatic note_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bracket_t want;
    if (!rst && done) begin
      if (awaited_brackets.size() == 0) begin
        mismatches++;
        $display("%0t: result with no query outstanding: found %0b before %0h after %0h",
                 $time, found, before_stamp, after_stamp);
      end else begin
        want = awaited_brackets[0];
        awaited_brackets.delete(0);
        note_field("found",        want.found,           found);
        note_field("before_stamp", want.earlier.stamp,   before_stamp);
        note_field("before_w",     16'(want.earlier.q.w), 16'(before_w));
        note_field("before_x",     16'(want.earlier.q.x), 16'(before_x));
        note_field("before_y",     16'(want.earlier.q.y), 16'(before_y));
        note_field("before_z",     16'(want.earlier.q.z), 16'(before_z));
        note_field("after_stamp",  want.later.stamp,     after_stamp);
        note_field("after_w",      16'(want.later.q.w),   16'(after_w));
        note_field("after_x",      16'(want.later.q.x),   16'(after_x));
        note_field("after_y",      16'(want.later.q.y),   16'(after_y));
        note_field("after_z",      16'(want.later.q.z),   16'(after_z));
      end
    end
  end

  // Watchdog: count cycles in which no request is taken and no result shows.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timestamped_sample_bracket_buffer verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register access and stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic window_write(input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    window_model = value[WINDOW_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic window_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WINDOW_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    note_field("window_ns readback", 64'(window_model), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold until every request is taken and every result is in, then let the
  // longest push finish ageing out samples before anything else happens.
  task automatic drain();
    do @(negedge clk);
    while (pending_requests.size() > 0 || start || awaited_brackets.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_push(input logic [STAMP_W-1:0] t, input logic [15:0] w,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
    request_t r;
    r.op = tsbb_pkg::OP_PUSH;
    r.stamp = t;
    r.q = {w, x, y, z};
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic queue_query(input logic [STAMP_W-1:0] t);
    request_t r;
    r.op = tsbb_pkg::OP_QUERY;
    r.stamp = t;
    r.q = {$urandom, $urandom};
    pending_requests.insert(pending_requests.size(), r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly rising sample streams with queries spread around the held span;
  // a share of backward steps, stamps anywhere in range and garbled requests.
  task automatic queue_random(input int count, input logic [63:0] step_max);
    request_t r;
    int kind;
    int pick;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      pick = $urandom_range(99);
      r.q = {$urandom, $urandom};
      if (kind < 48) begin
        r.op = tsbb_pkg::OP_PUSH;
        if (pick < 86)
          clock_ns = clock_ns + STAMP_W'(rand64() % (step_max + 1));
        else if (pick < 95)
          clock_ns = clock_ns - STAMP_W'(rand64() % (step_max * 4 + 1));
        else
          clock_ns = STAMP_W'(rand64());
        r.stamp = clock_ns;
        recent_stamps.insert(recent_stamps.size(), clock_ns);
        if (recent_stamps.size() > 80) recent_stamps.delete(0);
      end else if (kind < 97) begin
        r.op = tsbb_pkg::OP_QUERY;
        if (pick < 35 || recent_stamps.size() == 0)
          r.stamp = clock_ns - STAMP_W'(rand64() % (step_max * DEPTH + 1));
        else if (pick < 60)
          r.stamp = recent_stamps[$urandom_range(recent_stamps.size() - 1)];
        else if (pick < 70)
          r.stamp = recent_stamps[$urandom_range(recent_stamps.size() - 1)] + 1'b1;
        else if (pick < 85)
          r.stamp = STAMP_W'(rand64());
        else if (pick < 92)
          r.stamp = clock_ns + STAMP_W'($urandom_range(3));
        else
          r.stamp = $urandom_range(1) ? STAMP_MAX : '0;
      end else begin
        r.op = $urandom_range(1) ? tsbb_pkg::OP_QUERY : tsbb_pkg::OP_PUSH;
        r.stamp = STAMP_W'(rand64());
      end
      pending_requests.insert(pending_requests.size(), r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] win;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Window must come out of reset at its default.
    window_readback();

    // Directed: empty and single-sample rings, exact hits, out-of-span times,
    // a stamp that goes backwards, ageing down to two samples and the top stamp.
    idle_pct = 0;
    queue_query('0);
    queue_push(63'd1000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    queue_query(63'd1000);
    queue_push(63'd2000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
    queue_query(63'd1500);
    queue_query(63'd1000);
    queue_query(63'd2000);
    queue_query(63'd2001);
    queue_query(STAMP_MAX);
    queue_query('0);
    queue_push(63'd1500, 16'h1234, 16'hEDCB, 16'h4000, 16'hC000);
    queue_query(63'd1200);
    queue_push(63'd500002001, 16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA);
    queue_query(63'd1500);
    // oldest stamp above the newest: ageing must stop at once
    queue_push(63'd100, 16'hC000, 16'h4000, 16'h8001, 16'h7FFE);
    queue_query(63'd200);
    queue_query(63'd500000000);
    queue_push(STAMP_MAX, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF);
    queue_query(STAMP_MAX);
    queue_query(63'd101);
    drain();

    // A wide window with small steps: the ring fills and wraps over itself.
    window_write(WINDOW_TOP);
    window_readback();
    clock_ns = STAMP_W'(rand64() >> 2);
    queue_random(260, 64'd20000000);
    drain();

    // Zero window: a push ages out oldest samples until two remain or an oldest stamp is not below the new one.
    window_write(64'd0);
    window_readback();
    idle_pct = 57;
    queue_random(180, 64'd1000);
    drain();

    // Narrow random window, light idling.
    win = $urandom_range(1000000, 1000);
    window_write(win);
    window_readback();
    idle_pct = 25;
    queue_random(250, win / 4 + 1);
    drain();

    // Back to the default window, back to back.
    window_write(64'(tsbb_pkg::WINDOW_RESET));
    window_readback();
    idle_pct = 0;
    queue_random(180, 64'd50000000);
    drain();

    // Random window from zero up to WINDOW_TOP, heavy idling.
    win = rand64() % (WINDOW_TOP + 1);
    window_write(win);
    window_readback();
    idle_pct = 57;
    queue_random(180, win / 20 + 1);
    drain();

    if (mismatches == 0)
      $display("timestamped_sample_bracket_buffer verification clean");
    else
      $display("timestamped_sample_bracket_buffer verification failed");
    $finish;
  end

endmodule

### filelist.f
src/tsbb_pkg.sv
src/tsbb_ram.sv
src/tsbb_regs.sv
src/timestamped_sample_bracket_buffer.sv
bench/testbench.sv
